// ===== design/uttc_pkg.sv =====
// uttc_pkg: types, constants and the microprogram for the Unix time to calendar unit.
// No dependencies; imported by every module of the block.
package uttc_pkg;

    // Step counter width and step addresses of the microprogram
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT  = 3'd0;
    localparam step_t STEP_SEC   = 3'd1;
    localparam step_t STEP_MIN   = 3'd2;
    localparam step_t STEP_HOUR  = 3'd3;
    localparam step_t STEP_YEAR  = 3'd4;
    localparam step_t STEP_MONTH = 3'd5;
    localparam step_t STEP_EMIT  = 3'd6;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_WAIT  = 3'd0,
        OP_DIV   = 3'd1,
        OP_YEAR  = 3'd2,
        OP_MONTH = 3'd3,
        OP_EMIT  = 3'd4
    } op_t;

    typedef enum logic {
        DSEL_60 = 1'b0,
        DSEL_24 = 1'b1
    } dsel_t;

    typedef enum logic [1:0] {
        DST_SEC  = 2'd0,
        DST_MIN  = 2'd1,
        DST_HOUR = 2'd2
    } dst_t;

    typedef struct packed {
        op_t   op;
        dsel_t dsel;
        dst_t  dst;
        step_t nxt;
    } ctrl_t;

    // Completion flags fed back to the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic div_last;
        logic year_done;
        logic month_done;
    } status_t;

    // Field widths
    localparam int TS_W    = 31;
    localparam int YEAR_W  = 11;
    localparam int MON_W   = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int DAYS_W  = 15;   // whole days up to 24855
    localparam int WORK_W  = 31;   // dividend / quotient register
    localparam int DCNT_W  = 1;    // division phase counter: multiply, then remainder
    localparam int REM_W   = 6;
    localparam int MUL_W   = 32;   // reciprocal width
    localparam int PROD_W  = 63;   // dividend times reciprocal

    typedef struct packed {
        logic [TS_W-1:0]   counter;
        logic [SEC_W-1:0]  second;
        logic [MIN_W-1:0]  minute;
        logic [HOUR_W-1:0] hour;
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
    } result_t;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 11'd1970;
    localparam logic [1:0]        EPOCH_Y4   = 2'd2;    // 1970 mod 4
    localparam logic [6:0]        EPOCH_Y100 = 7'd70;   // 1970 mod 100
    localparam logic [8:0]        EPOCH_Y400 = 9'd370;  // 1970 mod 400
    localparam logic [6:0]        Y100_LAST  = 7'd99;
    localparam logic [8:0]        Y400_LAST  = 9'd399;

    localparam logic [8:0] DAYS_YEAR      = 9'd365;
    localparam logic [8:0] DAYS_LEAP_YEAR = 9'd366;
    localparam logic [MON_W-1:0] MON_DEC  = 4'd11;

    // Constant divisors and their reciprocals, exact for any 31-bit dividend:
    // quotient = (x * RECIP) >> SHIFT
    localparam logic [REM_W-1:0] DIV_60   = 6'd60;
    localparam logic [REM_W-1:0] DIV_24   = 6'd24;
    localparam logic [MUL_W-1:0] RECIP_60 = 32'd2290649225;  // ceil(2^37 / 60)
    localparam logic [MUL_W-1:0] RECIP_24 = 32'd2863311531;  // ceil(2^36 / 24)
    localparam int               SHIFT_60 = 37;
    localparam int               SHIFT_24 = 36;

    // Month length, month index 0 is January
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (mon)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Microprogram ROM
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t cw;
        case (step)
            STEP_WAIT:  cw = '{op: OP_WAIT,  dsel: DSEL_60, dst: DST_SEC,  nxt: STEP_SEC};
            STEP_SEC:   cw = '{op: OP_DIV,   dsel: DSEL_60, dst: DST_SEC,  nxt: STEP_MIN};
            STEP_MIN:   cw = '{op: OP_DIV,   dsel: DSEL_60, dst: DST_MIN,  nxt: STEP_HOUR};
            STEP_HOUR:  cw = '{op: OP_DIV,   dsel: DSEL_24, dst: DST_HOUR, nxt: STEP_YEAR};
            STEP_YEAR:  cw = '{op: OP_YEAR,  dsel: DSEL_60, dst: DST_SEC,  nxt: STEP_MONTH};
            STEP_MONTH: cw = '{op: OP_MONTH, dsel: DSEL_60, dst: DST_SEC,  nxt: STEP_EMIT};
            STEP_EMIT:  cw = '{op: OP_EMIT,  dsel: DSEL_60, dst: DST_SEC,  nxt: STEP_WAIT};
            default:    cw = '{op: OP_WAIT,  dsel: DSEL_60, dst: DST_SEC,  nxt: STEP_WAIT};
        endcase
        return cw;
    endfunction

endpackage

// ===== design/uttc_sequencer.sv =====
// uttc_sequencer: step counter and microprogram ROM lookup.
// Depends on uttc_pkg (ctrl_t, status_t, ucode).
module uttc_sequencer
    import uttc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  status_t status,
    output ctrl_t   ctrl,
    output logic    adv
);

    step_t step_reg, step_next;

    always_comb begin
        ctrl = ucode(step_reg);
        case (ctrl.op)
            OP_WAIT:  adv = status.in_valid;
            OP_DIV:   adv = status.div_last;
            OP_YEAR:  adv = status.year_done;
            OP_MONTH: adv = status.month_done;
            OP_EMIT:  adv = status.out_free;
            default:  adv = 1'b1;
        endcase
        // conditional jump: hold the step until its exit condition is met
        step_next = adv ? ctrl.nxt : step_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== design/uttc_datapath.sv =====
// uttc_datapath: reciprocal-multiply constant divider, year and month walk registers.
// Depends on uttc_pkg; driven by the control word of uttc_sequencer.
module uttc_datapath
    import uttc_pkg::*;
(
    input  logic            aclk,
    input  ctrl_t           ctrl,
    input  logic            adv,
    input  logic [TS_W-1:0] ts_in,
    output logic            div_last,
    output logic            year_done,
    output logic            month_done,
    output result_t         result
);

    logic [WORK_W-1:0] work_reg, work_next;
    logic [WORK_W-1:0] quo_reg, quo_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic [MIN_W-1:0]  min_reg, min_next;
    logic [HOUR_W-1:0] hour_reg, hour_next;
    logic [DAYS_W-1:0] days_reg, days_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic [1:0]        y4_reg, y4_next;
    logic [6:0]        y100_reg, y100_next;
    logic [8:0]        y400_reg, y400_next;
    logic [MON_W-1:0]  mon_reg, mon_next;

    logic [MUL_W-1:0]   recip;
    logic [REM_W-1:0]   dval;
    logic [PROD_W-1:0]  prod;
    logic [WORK_W-1:0]  quo_est;
    logic [2*REM_W-1:0] qd;
    logic [REM_W-1:0]   rem_new;
    logic               leap;
    logic [8:0]         ylen;
    logic [DAY_W-1:0]   mlen;

    // quotient by reciprocal multiply first, then the remainder from the low bits
    always_comb begin
        recip   = (ctrl.dsel == DSEL_24) ? RECIP_24 : RECIP_60;
        dval    = (ctrl.dsel == DSEL_24) ? DIV_24 : DIV_60;
        prod    = {{(PROD_W-WORK_W){1'b0}}, work_reg} * {{(PROD_W-MUL_W){1'b0}}, recip};
        quo_est = (ctrl.dsel == DSEL_24) ?
                  {{(WORK_W-PROD_W+SHIFT_24){1'b0}}, prod[PROD_W-1:SHIFT_24]} :
                  {{(WORK_W-PROD_W+SHIFT_60){1'b0}}, prod[PROD_W-1:SHIFT_60]};
        qd      = {{REM_W{1'b0}}, quo_reg[REM_W-1:0]} * {{REM_W{1'b0}}, dval};
        rem_new = work_reg[REM_W-1:0] - qd[REM_W-1:0];
    end

    assign leap = (y4_reg == 2'd0) && ((y100_reg != 7'd0) || (y400_reg == 9'd0));
    assign ylen = leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
    assign mlen = month_len(mon_reg, leap);

    assign div_last   = (dcnt_reg == {DCNT_W{1'b1}});
    assign year_done  = (days_reg < DAYS_W'(ylen));
    assign month_done = (mon_reg == MON_DEC) || (days_reg < DAYS_W'(mlen));

    always_comb begin
        work_next = work_reg;
        quo_next  = quo_reg;
        dcnt_next = dcnt_reg;
        ts_next   = ts_reg;
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        days_next = days_reg;
        year_next = year_reg;
        y4_next   = y4_reg;
        y100_next = y100_reg;
        y400_next = y400_reg;
        mon_next  = mon_reg;
        case (ctrl.op)
            OP_WAIT: begin
                if (adv) begin
                    work_next = ts_in;
                    ts_next   = ts_in;
                    dcnt_next = '0;
                    year_next = EPOCH_YEAR;
                    y4_next   = EPOCH_Y4;
                    y100_next = EPOCH_Y100;
                    y400_next = EPOCH_Y400;
                    mon_next  = '0;
                end
            end
            OP_DIV: begin
                dcnt_next = dcnt_reg + 1'b1;
                if (!adv) begin
                    quo_next = quo_est;
                end else begin
                    work_next = quo_reg;
                    case (ctrl.dst)
                        DST_SEC:  sec_next  = rem_new;
                        DST_MIN:  min_next  = rem_new;
                        DST_HOUR: begin
                            hour_next = HOUR_W'(rem_new);
                            days_next = quo_reg[DAYS_W-1:0];
                        end
                        default:  sec_next  = rem_new;
                    endcase
                end
            end
            OP_YEAR: begin
                if (!adv) begin
                    days_next = days_reg - DAYS_W'(ylen);
                    year_next = year_reg + 1'b1;
                    y4_next   = y4_reg + 1'b1;
                    y100_next = (y100_reg == Y100_LAST) ? 7'd0 : y100_reg + 1'b1;
                    y400_next = (y400_reg == Y400_LAST) ? 9'd0 : y400_reg + 1'b1;
                end
            end
            OP_MONTH: begin
                if (!adv) begin
                    days_next = days_reg - DAYS_W'(mlen);
                    mon_next  = mon_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        quo_reg  <= quo_next;
        dcnt_reg <= dcnt_next;
        ts_reg   <= ts_next;
        sec_reg  <= sec_next;
        min_reg  <= min_next;
        hour_reg <= hour_next;
        days_reg <= days_next;
        year_reg <= year_next;
        y4_reg   <= y4_next;
        y100_reg <= y100_next;
        y400_reg <= y400_next;
        mon_reg  <= mon_next;
    end

    always_comb begin
        result.year    = year_reg;
        result.month   = mon_reg + 1'b1;
        result.day     = DAY_W'(days_reg) + 1'b1;
        result.hour    = hour_reg;
        result.minute  = min_reg;
        result.second  = sec_reg;
        result.counter = ts_reg;
    end

endmodule

// ===== design/unix_time_to_calendar_unit.sv =====
// unix_time_to_calendar_unit: top level of the Unix time to calendar converter.
// Depends on uttc_pkg, uttc_sequencer and uttc_datapath.
//
//  channel | dir | ports                      | word
//  --------+-----+----------------------------+----------------------------------
//  input   | in  | s_tvalid s_tready s_tdata  | timestamp seconds since 1970
//  result  | out | m_tvalid m_tready m_tdata  | date, time of day, echoed counter
//
// Each word passes the load step, three divisions (each a reciprocal multiply, then
// a remainder), the year walk from 1970, the month walk and the emit step. The year
// walk, held in its step by the sequencer, takes the largest share of that.
// Reset (aresetn low, synchronous) returns the step counter to the wait step,
// holds s_tready low and empties the output register. A stalled result sits in
// the output register while the next word is taken and converted; only the emit
// step waits.
module unix_time_to_calendar_unit
    import uttc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] timestamp, [31] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [10:0] year, [14:11] month, [19:15] day,
                                   // [24:20] hour, [30:25] minute, [36:31] second,
                                   // [67:37] counter, [71:68] zero
);

    ctrl_t   ctrl;
    logic    adv;
    status_t status;
    result_t result;
    logic    div_last, year_done, month_done;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [71:0] m_tdata_reg, m_tdata_next;
    logic        emit_fire;

    // ready only on the wait step of the program, never in reset
    assign s_tready = aresetn && (ctrl.op == OP_WAIT);

    always_comb begin
        status.in_valid   = s_tvalid;
        status.out_free   = !m_tvalid_reg || m_tready;
        status.div_last   = div_last;
        status.year_done  = year_done;
        status.month_done = month_done;
    end

    uttc_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl),
        .adv     (adv)
    );

    uttc_datapath u_dp (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .adv        (adv),
        .ts_in      (s_tdata[TS_W-1:0]),
        .div_last   (div_last),
        .year_done  (year_done),
        .month_done (month_done),
        .result     (result)
    );

    // output register: loaded on the emit step, cleared when taken
    assign emit_fire = (ctrl.op == OP_EMIT) && adv;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (emit_fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'd0, result.counter, result.second, result.minute,
                             result.hour, result.day, result.month, result.year};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
